// ----- hw/rtl/fbpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Shared constants, codes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int LINK_W     = $clog2(MAX_BLOCKS + 2);
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 16;
  localparam int CNT_W      = 9;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 2;

  localparam logic [LINK_W-1:0] LINK_NULL     = LINK_W'(MAX_BLOCKS);
  localparam logic [LINK_W-1:0] LINK_DETACHED = LINK_W'(MAX_BLOCKS + 1);

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNALIGNED = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STAT_W-1:0] ST_DOUBLE    = 3'd4;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd2;

  localparam logic [SIZE_W-1:0] BLOCK_BYTES_RST = 16'd16;
  localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = CNT_W'(MAX_BLOCKS);

  typedef struct packed {
    logic              accept;
    logic              div_start;
    logic              rd_head;
    logic              rd_index;
    logic              alloc_commit;
    logic              rel_commit;
    logic              finish;
    logic [STAT_W-1:0] code;
  } fbpa_cmd_t;

  typedef struct packed {
    logic empty;
    logic div_done;
    logic rem_nz;
    logic range_bad;
    logic detached;
  } fbpa_sts_t;

endpackage

// ----- hw/rtl/fbpa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/fbpa_div.sv -----
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division of a 32-bit dividend by a 16-bit divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module fbpa_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fbpa_pkg::ADDR_W-1:0] dividend_i,
  input  logic [fbpa_pkg::SIZE_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [fbpa_pkg::ADDR_W-1:0] quotient_o,
  output logic [fbpa_pkg::SIZE_W-1:0] remainder_o
);
  import fbpa_pkg::*;

  localparam int STEP_W = $clog2(ADDR_W);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [ADDR_W-1:0] quo_q, quo_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [SIZE_W-1:0] dvs_q, dvs_d;
  logic [SIZE_W:0]   trial;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[ADDR_W-1]};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = STEP_W'(ADDR_W - 1);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (run_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = SIZE_W'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[ADDR_W-2:0], 1'b1};
      end else begin
        rem_d = trial[SIZE_W-1:0];
        quo_d = {quo_q[ADDR_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- hw/rtl/fbpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences allocate and release requests and chooses the result status.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                kind_i,
  input  fbpa_pkg::fbpa_sts_t sts_i,
  output fbpa_pkg::fbpa_cmd_t cmd_o,
  output logic                busy_o
);
  import fbpa_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_A_RD   = 3'd1;
  localparam logic [2:0] S_A_WR   = 3'd2;
  localparam logic [2:0] S_R_DIV  = 3'd3;
  localparam logic [2:0] S_R_WAIT = 3'd4;
  localparam logic [2:0] S_R_CHK  = 3'd5;
  localparam logic [2:0] S_R_WR   = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [STAT_W-1:0] code_q, code_d;

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if (kind_i == KIND_RELEASE) begin
            state_d = S_R_DIV;
          end else if (sts_i.empty) begin
            code_d  = ST_EMPTY;
            state_d = S_FIN;
          end else begin
            state_d = S_A_RD;
          end
        end
      end
      S_A_RD: begin
        cmd_o.rd_head = 1'b1;
        state_d       = S_A_WR;
      end
      S_A_WR: begin
        cmd_o.alloc_commit = 1'b1;
        code_d             = ST_OK;
        state_d            = S_FIN;
      end
      S_R_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_R_WAIT;
      end
      S_R_WAIT: begin
        if (sts_i.div_done) begin
          state_d = S_R_CHK;
        end
      end
      S_R_CHK: begin
        priority if (sts_i.rem_nz) begin
          code_d  = ST_UNALIGNED;
          state_d = S_FIN;
        end else if (sts_i.range_bad) begin
          code_d  = ST_RANGE;
          state_d = S_FIN;
        end else begin
          cmd_o.rd_index = 1'b1;
          state_d        = S_R_WR;
        end
      end
      S_R_WR: begin
        if (sts_i.detached) begin
          cmd_o.rel_commit = 1'b1;
          code_d           = ST_OK;
        end else begin
          code_d = ST_DOUBLE;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cmd_o.code = code_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- hw/rtl/fbpa_dp.sv -----
// ----------------------------------------------------------------------------
// Allocator datapath
// Holds the configuration, the free list and the result registers, and
// carries out the steps that the controller commands.
// ----------------------------------------------------------------------------
module fbpa_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fbpa_pkg::fbpa_cmd_t           cmd_i,
  output fbpa_pkg::fbpa_sts_t           sts_o,
  input  logic                          cfg_we_i,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]   cfg_data_i,
  input  logic                          kind_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]   release_address_i,
  output logic                          done_o,
  output logic [fbpa_pkg::STAT_W-1:0]   status_o,
  output logic [fbpa_pkg::ADDR_W-1:0]   granted_address_o,
  output logic [fbpa_pkg::CNT_W-1:0]    free_blocks_o
);
  import fbpa_pkg::*;

  logic [ADDR_W-1:0]     base_q, base_d;
  logic [SIZE_W-1:0]     bytes_q, bytes_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      n_cur, n_new;
  logic [SIZE_W-1:0]     size;
  logic                  rebuild;

  logic [MAX_BLOCKS-1:0] lv_q, lv_d;
  logic [IDX_W-1:0]      head_q, head_d;
  logic                  empty_q, empty_d;
  logic [CNT_W-1:0]      free_q, free_d;

  logic                  kind_q;
  logic [ADDR_W-1:0]     off_q;
  logic [ADDR_W-1:0]     mag;
  logic [IDX_W-1:0]      idx_q;
  logic                  lv_rd_q;
  logic [IDX_W+SIZE_W-1:0] prod_q;

  logic                  done_q;
  logic [STAT_W-1:0]     status_q;
  logic [ADDR_W-1:0]     granted_q;
  logic [CNT_W-1:0]      free_out_q;

  logic                  div_done;
  logic [ADDR_W-1:0]     quo;
  logic [SIZE_W-1:0]     rem;
  logic [IDX_W-1:0]      qidx;

  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [LINK_W-1:0]     ram_wdata, ram_rdata;
  logic [LINK_W-1:0]     link_dflt, link_eff;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (32'(c) > MAX_BLOCKS) begin
      r = CNT_W'(MAX_BLOCKS);
    end else begin
      r = c;
    end
    return r;
  endfunction

  assign n_cur = eff_count(count_q);
  assign size  = (bytes_q == '0) ? SIZE_W'(1) : bytes_q;
  assign mag   = off_q[ADDR_W-1] ? (~off_q + 1'b1) : off_q;
  assign qidx  = quo[IDX_W-1:0];

  always_comb begin
    base_d  = base_q;
    bytes_d = bytes_q;
    count_d = count_q;
    rebuild = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_POOL_BASE: begin
          base_d  = cfg_data_i;
          rebuild = 1'b1;
        end
        REG_BLOCK_BYTES: begin
          bytes_d = cfg_data_i[SIZE_W-1:0];
          rebuild = 1'b1;
        end
        REG_BLOCK_COUNT: begin
          count_d = cfg_data_i[CNT_W-1:0];
          rebuild = 1'b1;
        end
        default: begin
          rebuild = 1'b0;
        end
      endcase
    end
    n_new = eff_count(count_d);
  end

  assign link_dflt = (32'(idx_q) + 1 < 32'(n_cur)) ? LINK_W'(32'(idx_q) + 1) : LINK_NULL;
  assign link_eff  = lv_rd_q ? ram_rdata : link_dflt;

  assign ram_re    = cmd_i.rd_head | cmd_i.rd_index;
  assign ram_raddr = cmd_i.rd_head ? head_q : qidx;
  assign ram_we    = cmd_i.alloc_commit | cmd_i.rel_commit;
  assign ram_wdata = cmd_i.alloc_commit ? LINK_DETACHED :
                     (empty_q ? LINK_NULL : LINK_W'(head_q));

  always_comb begin
    lv_d    = lv_q;
    head_d  = head_q;
    empty_d = empty_q;
    free_d  = free_q;
    if (rebuild) begin
      lv_d    = '0;
      head_d  = '0;
      empty_d = 1'b0;
      free_d  = n_new;
    end else if (cmd_i.alloc_commit) begin
      lv_d[idx_q] = 1'b1;
      if (32'(link_eff) >= 32'(n_cur)) begin
        empty_d = 1'b1;
        head_d  = '0;
      end else begin
        head_d = link_eff[IDX_W-1:0];
      end
      free_d = free_q - 1'b1;
    end else if (cmd_i.rel_commit) begin
      lv_d[idx_q] = 1'b1;
      head_d      = idx_q;
      empty_d     = 1'b0;
      free_d      = free_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      bytes_q <= BLOCK_BYTES_RST;
      count_q <= BLOCK_COUNT_RST;
      lv_q    <= '0;
      head_q  <= '0;
      empty_q <= 1'b0;
      free_q  <= eff_count(BLOCK_COUNT_RST);
      done_q  <= 1'b0;
    end else begin
      base_q  <= base_d;
      bytes_q <= bytes_d;
      count_q <= count_d;
      lv_q    <= lv_d;
      head_q  <= head_d;
      empty_q <= empty_d;
      free_q  <= free_d;
      done_q  <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      off_q  <= release_address_i - base_q;
    end
    if (cmd_i.rd_head) begin
      idx_q   <= head_q;
      lv_rd_q <= lv_q[head_q];
    end else if (cmd_i.rd_index) begin
      idx_q   <= qidx;
      lv_rd_q <= lv_q[qidx];
    end
    if (cmd_i.alloc_commit) begin
      prod_q <= idx_q * size;
    end
    if (cmd_i.finish) begin
      status_q   <= cmd_i.code;
      free_out_q <= free_q;
      if (kind_q == KIND_ALLOC && cmd_i.code == ST_OK) begin
        granted_q <= base_q + ADDR_W'(prod_q);
      end else begin
        granted_q <= '0;
      end
    end
  end

  fbpa_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (mag),
    .divisor_i   (size),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  fbpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign sts_o.empty     = empty_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.rem_nz    = (rem != '0);
  assign sts_o.range_bad = off_q[ADDR_W-1] | (quo >= ADDR_W'(n_cur));
  assign sts_o.detached  = (link_eff == LINK_DETACHED);

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign granted_address_o = granted_q;
  assign free_blocks_o     = free_out_q;

endmodule

// ----- hw/rtl/fixed_block_pool_allocator_top.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Hands out and takes back equal-size blocks of a pool kept on a linked
// free list.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An allocate pops the
// head of the free list and returns its byte address; a release checks the
// address for alignment, range and double free and pushes the block back.
// Each request gives exactly one result, shown for one cycle with done_o high.
// An allocate reads the head link, then commits the pop and shows the result.
// A release runs the bit-serial divider, which turns the offset into a block
// index at one quotient bit per cycle, then reads the block's link unless
// the address is unaligned or out of range.
// The next request can be taken at the edge that ends the result cycle; no new
// request is taken while an earlier one is still in progress.
// The configuration channel is always ready. Writing one of the three
// registers rebuilds the free list at once, with every block free and chained
// in index order. Reset does the same with the default pool settings. Results
// cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           kind_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]    release_address_i,
  output logic                           done_o,
  output logic [fbpa_pkg::STAT_W-1:0]    status_o,
  output logic [fbpa_pkg::ADDR_W-1:0]    granted_address_o,
  output logic [fbpa_pkg::CNT_W-1:0]     free_blocks_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]    cfg_data_i
);
  import fbpa_pkg::*;

  fbpa_cmd_t cmd;
  fbpa_sts_t sts;

  assign cfg_ready_o = 1'b1;

  fbpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .kind_i (kind_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  fbpa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_valid_i & cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .kind_i            (kind_i),
    .release_address_i (release_address_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .free_blocks_o     (free_blocks_o)
  );

endmodule

// ----- tb/fixed_block_pool_allocator_top_tb.sv -----
// ----------------------------------------------------------------------------
// Fixed block pool allocator testbench
// Drives allocate and release requests on the command port and reprograms
// the pool in and between phases. A scoreboard keeps its own free list
// and checks every result. Directed cases cover the address extremes,
// wrap-around, empty pools, unaligned, out of range and double free releases,
// and the ignored register index. Random phases follow, with sender gaps.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_top_tb;
  import fbpa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int QUIET_LIMIT     = 2000;
  localparam int TAIL_CYCLES     = 45;
  localparam int ITEMS_PER_PHASE = 250;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] granted;
    logic [CNT_W-1:0]  free_blocks;
  } outcome_t;

  class pool_scoreboard;
    logic [ADDR_W-1:0] pool_base;
    logic [SIZE_W-1:0] block_bytes;
    logic [CNT_W-1:0]  block_count;
    logic [LINK_W-1:0] next_free [MAX_BLOCKS];
    logic [LINK_W-1:0] head;
    logic              pool_empty;
    logic [CNT_W-1:0]  free_total;
    outcome_t          pending[$];
    int                errors;
    int                requests;
    int                reg_writes;
    int                status_hits [5];

    function new();
      pool_base   = '0;
      block_bytes = BLOCK_BYTES_RST;
      block_count = BLOCK_COUNT_RST;
      errors      = 0;
      requests    = 0;
      reg_writes  = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
      rebuild_free_list();
    endfunction

    function int unsigned blocks_in_use();
      if (block_count == 0) return 1;
      if (block_count > MAX_BLOCKS) return MAX_BLOCKS;
      return block_count;
    endfunction

    function int unsigned bytes_per_block();
      return (block_bytes == 0) ? 1 : block_bytes;
    endfunction

    function void rebuild_free_list();
      int unsigned n;
      n = blocks_in_use();
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        next_free[i] = (i + 1 < n) ? LINK_W'(i + 1) : LINK_NULL;
      end
      head       = '0;
      pool_empty = 1'b0;
      free_total = CNT_W'(n);
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] index, logic [ADDR_W-1:0] data);
      reg_writes++;
      case (index)
        REG_POOL_BASE:   pool_base   = data;
        REG_BLOCK_BYTES: block_bytes = data[SIZE_W-1:0];
        REG_BLOCK_COUNT: block_count = data[CNT_W-1:0];
        default:         return;
      endcase
      rebuild_free_list();
    endfunction

    function outcome_t next_outcome(logic kind, logic [ADDR_W-1:0] address);
      outcome_t          result;
      int unsigned       size;
      int unsigned       n;
      logic [LINK_W-1:0] index;
      logic [LINK_W-1:0] follower;
      logic [ADDR_W-1:0] offset;
      logic [ADDR_W-1:0] magnitude;
      size = bytes_per_block();
      n = blocks_in_use();
      result.status  = ST_OK;
      result.granted = '0;
      if (kind == KIND_ALLOC) begin
        if (pool_empty) begin
          result.status = ST_EMPTY;
        end else begin
          index    = head;
          follower = next_free[index];
          if (follower >= n) begin
            pool_empty = 1'b1;
            head       = '0;
          end else begin
            head = follower;
          end
          next_free[index] = LINK_DETACHED;
          free_total--;
          result.granted = pool_base + ADDR_W'(index) * size;
        end
      end else begin
        offset    = address - pool_base;
        magnitude = offset[ADDR_W-1] ? 32'd0 - offset : offset;
        if (magnitude % size != 0) begin
          result.status = ST_UNALIGNED;
        end else if (offset[ADDR_W-1] || magnitude / size >= n) begin
          result.status = ST_RANGE;
        end else begin
          index = LINK_W'(magnitude / size);
          if (next_free[index] != LINK_DETACHED) begin
            result.status = ST_DOUBLE;
          end else begin
            next_free[index] = pool_empty ? LINK_NULL : head;
            head       = index;
            pool_empty = 1'b0;
            free_total++;
          end
        end
      end
      result.free_blocks = free_total;
      return result;
    endfunction

    function outcome_t note_request(logic kind, logic [ADDR_W-1:0] address);
      outcome_t result;
      result = next_outcome(kind, address);
      pending.push_back(result);
      requests++;
      status_hits[result.status]++;
      return result;
    endfunction

    function void check_outcome(logic [STAT_W-1:0] status, logic [ADDR_W-1:0] granted,
                                logic [CNT_W-1:0] free_blocks);
      outcome_t awaited;
      if (pending.size() == 0) begin
        $display("%0t: result with none expected: status %0d, address %h, free %0d",
                 $time, status, granted, free_blocks);
        errors++;
        return;
      end
      awaited = pending.pop_front();
      if (status !== awaited.status) begin
        $display("%0t: status expected %0d, actual %0d", $time, awaited.status, status);
        errors++;
      end
      if (granted !== awaited.granted) begin
        $display("%0t: granted address expected %h, actual %h",
                 $time, awaited.granted, granted);
        errors++;
      end
      if (free_blocks !== awaited.free_blocks) begin
        $display("%0t: free blocks expected %0d, actual %0d",
                 $time, awaited.free_blocks, free_blocks);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i             = 1'b0;
  logic                 rst_ni            = 1'b0;
  logic                 start             = 1'b0;
  logic                 busy;
  logic                 kind_i            = KIND_ALLOC;
  logic [ADDR_W-1:0]    release_address_i = '0;
  logic                 done_o;
  logic [STAT_W-1:0]    status_o;
  logic [ADDR_W-1:0]    granted_address_o;
  logic [CNT_W-1:0]     free_blocks_o;
  logic                 cfg_valid_i       = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i       = REG_POOL_BASE;
  logic [ADDR_W-1:0]    cfg_data_i        = '0;

  pool_scoreboard    sb;
  logic [ADDR_W-1:0] held_addrs[$];
  int                quiet_cycles = 0;

  fixed_block_pool_allocator_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .kind_i            (kind_i),
    .release_address_i (release_address_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .free_blocks_o     (free_blocks_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin : monitor
    outcome_t noted;
    if (rst_ni) begin
      quiet_cycles++;
      if (done_o) begin
        sb.check_outcome(status_o, granted_address_o, free_blocks_o);
        quiet_cycles = 0;
      end
      if (start && !busy) begin
        noted = sb.note_request(kind_i, release_address_i);
        if (kind_i == KIND_ALLOC && noted.status == ST_OK) held_addrs.push_back(noted.granted);
        quiet_cycles = 0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.write_register(cfg_index_i, cfg_data_i);
        quiet_cycles = 0;
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  task automatic idle_gap(int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic issue_request(logic kind, logic [ADDR_W-1:0] address);
    start             <= 1'b1;
    kind_i            <= kind;
    release_address_i <= address;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain_requests();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [ADDR_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure_pool(logic [ADDR_W-1:0] base_word, logic [ADDR_W-1:0] bytes_word,
                                logic [ADDR_W-1:0] count_word);
    drain_requests();
    write_reg(REG_POOL_BASE, base_word);
    write_reg(REG_BLOCK_BYTES, bytes_word);
    write_reg(REG_BLOCK_COUNT, count_word);
    cfg_valid_i <= 1'b0;
    held_addrs.delete();
  endtask

  task automatic write_unused();
    drain_requests();
    write_reg(REG_UNUSED, $urandom());
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_setup();
    logic [ADDR_W-1:0] base_word;
    logic [ADDR_W-1:0] bytes_word;
    logic [ADDR_W-1:0] count_word;
    case ($urandom_range(3))
      0:       base_word = $urandom();
      1:       base_word = 32'hFFFF_FFFF - $urandom_range(4095);
      2:       base_word = $urandom_range(4095);
      default: base_word = $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
    endcase
    case ($urandom_range(9))
      0:       bytes_word = 32'h0;
      1:       bytes_word = 32'hFFFF;
      2, 3, 4: bytes_word = 32'd1 << $urandom_range(15);
      5, 6, 7: bytes_word = $urandom_range(1, 20);
      default: bytes_word = $urandom_range(65535);
    endcase
    case ($urandom_range(9))
      0:       count_word = 32'h0;
      1:       count_word = $urandom_range(13, 256);
      2:       count_word = $urandom_range(257, 511);
      default: count_word = $urandom_range(1, 12);
    endcase
    if ($urandom_range(1)) begin
      bytes_word[31:16] = 16'($urandom());
      count_word[31:9]  = 23'($urandom());
    end
    configure_pool(base_word, bytes_word, count_word);
  endtask

  initial begin : stimulus
    int                idle_pct;
    int                pick;
    int                slot;
    int unsigned       n;
    int unsigned       size;
    logic              kind;
    logic [ADDR_W-1:0] address;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue_request(KIND_ALLOC, 32'hFFFF_FFFF);
    issue_request(KIND_RELEASE, 32'h0000_0000);
    issue_request(KIND_RELEASE, 32'h0000_0000);
    issue_request(KIND_RELEASE, 32'h0000_0008);
    issue_request(KIND_RELEASE, 32'h0000_1000);
    issue_request(KIND_RELEASE, 32'hFFFF_FFF0);
    issue_request(KIND_RELEASE, 32'hFFFF_FFF8);
    issue_request(KIND_RELEASE, 32'h8000_0000);
    issue_request(KIND_RELEASE, 32'h0000_0FF0);

    configure_pool(32'hFFFF_FFF0, 32'hABCD_0010, 32'hFFFF_0002);
    issue_request(KIND_ALLOC, 32'h0);
    issue_request(KIND_ALLOC, 32'h0);
    issue_request(KIND_ALLOC, 32'h0);
    issue_request(KIND_RELEASE, 32'h0000_0000);
    issue_request(KIND_RELEASE, 32'hFFFF_FFF0);
    issue_request(KIND_ALLOC, 32'h5555_AAAA);

    configure_pool(32'h0, 32'h0, 32'h0);
    issue_request(KIND_ALLOC, 32'h0);
    issue_request(KIND_ALLOC, 32'h0);
    issue_request(KIND_RELEASE, 32'h0000_0001);
    issue_request(KIND_RELEASE, 32'h0000_0000);

    configure_pool(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_01FF);
    issue_request(KIND_ALLOC, 32'h0);
    issue_request(KIND_ALLOC, 32'h0);
    write_unused();
    issue_request(KIND_RELEASE, 32'h0000_FFFE);
    issue_request(KIND_RELEASE, 32'hFFFF_FFFF + 32'd256 * 32'hFFFF);
    issue_request(KIND_RELEASE, 32'h0000_FFFF);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 31 : (phase == 1) ? 60 : 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 50 == 0) begin
          if (i != 0 && $urandom_range(3) == 0) write_unused();
          else random_setup();
        end else if (i % 50 == 25) begin
          drain_requests();
        end
        n       = sb.blocks_in_use();
        size    = sb.bytes_per_block();
        pick    = $urandom_range(99);
        kind    = KIND_RELEASE;
        address = $urandom();
        if (pick < 45 || (pick < 80 && held_addrs.size() == 0)) begin
          kind = KIND_ALLOC;
        end else if (pick < 80) begin
          slot    = $urandom_range(held_addrs.size() - 1);
          address = held_addrs[slot];
          if ($urandom_range(9) != 0) held_addrs.delete(slot);
        end else begin
          case ($urandom_range(3))
            0:       ;
            1:       address = sb.pool_base + $urandom_range(n + 2) * size
                               + $urandom_range(size - 1);
            2:       address = sb.pool_base - $urandom_range(1, 4) * size;
            default: address = sb.pool_base + $urandom_range(n - 1) * size;
          endcase
        end
        idle_gap(idle_pct);
        issue_request(kind, address);
      end
    end

    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests and %0d register writes across three gap profiles.",
             sb.requests, sb.reg_writes);
    $display("Outcomes: %0d ok, %0d empty, %0d unaligned, %0d out of range, %0d double free.",
             sb.status_hits[ST_OK], sb.status_hits[ST_EMPTY], sb.status_hits[ST_UNALIGNED],
             sb.status_hits[ST_RANGE], sb.status_hits[ST_DOUBLE]);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_ram.sv
hw/rtl/fbpa_div.sv
hw/rtl/fbpa_ctrl.sv
hw/rtl/fbpa_dp.sv
hw/rtl/fixed_block_pool_allocator_top.sv
tb/fixed_block_pool_allocator_top_tb.sv
